// ===== rtl/fzc_pkg.sv =====
package fzc_pkg;

    localparam int ACC_BITS       = 16;
    localparam int SPAN_BITS      = 16;
    localparam int MIC_BITS_DEF   = 12;
    localparam int FRAC_BITS_DEF  = 15;
    localparam int CLASS_BITS     = 2;
    localparam int RULE_BITS      = 4;
    localparam int STRENGTH_BITS  = 31;
    localparam int OUT_DATA_BITS  = 40;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_ADDR_BITS  = 6;
    localparam int CFG_IDX_LSB    = 3;

    // Q8.8 breakpoints: 17.79, 27.44, 18.49, 26.94, 31.83, 27.44, 31.33
    localparam logic [ACC_BITS-1:0] ACC_LOW_START_RST  = 16'd4554;
    localparam logic [ACC_BITS-1:0] ACC_LOW_END_RST    = 16'd7025;
    localparam logic [ACC_BITS-1:0] ACC_MID_START_RST  = 16'd4733;
    localparam logic [ACC_BITS-1:0] ACC_MID_PEAK_RST   = 16'd6897;
    localparam logic [ACC_BITS-1:0] ACC_MID_END_RST    = 16'd8148;
    localparam logic [ACC_BITS-1:0] ACC_HIGH_START_RST = 16'd7025;
    localparam logic [ACC_BITS-1:0] ACC_HIGH_END_RST   = 16'd8020;

    localparam int MIC_START_RST = 473;
    localparam int MIC_PEAK_RST  = 542;
    localparam int MIC_END_RST   = 591;

    typedef enum logic [1:0] {
        DM_ZERO = 2'd0,
        DM_ONE  = 2'd1,
        DM_DIV  = 2'd2
    } deg_mode_t;

    typedef enum logic [CLASS_BITS-1:0] {
        CLASS_NORMAL = 2'd0,
        CLASS_ALERT  = 2'd1,
        CLASS_FALL   = 2'd2
    } class_t;

    typedef enum logic [2:0] {
        REG_ACC_LOW_START  = 3'd0,
        REG_ACC_LOW_END    = 3'd1,
        REG_ACC_MID_START  = 3'd2,
        REG_ACC_MID_PEAK   = 3'd3,
        REG_ACC_MID_END    = 3'd4,
        REG_ACC_HIGH_START = 3'd5,
        REG_ACC_HIGH_END   = 3'd6,
        REG_MIC_BPS        = 3'd7
    } cfg_reg_t;

    typedef logic signed [ACC_BITS:0] pt_t;

    typedef struct packed {
        logic [ACC_BITS-1:0] low_start;
        logic [ACC_BITS-1:0] low_end;
        logic [ACC_BITS-1:0] mid_start;
        logic [ACC_BITS-1:0] mid_peak;
        logic [ACC_BITS-1:0] mid_end;
        logic [ACC_BITS-1:0] high_start;
        logic [ACC_BITS-1:0] high_end;
    } acc_cfg_t;

    typedef struct packed {
        deg_mode_t            mode;
        logic [SPAN_BITS-1:0] num;
        logic [SPAN_BITS-1:0] den;
    } deg_sel_t;

    typedef struct packed {
        class_t                   cls;
        logic [RULE_BITS-1:0]     idx;
        logic [STRENGTH_BITS-1:0] strength;
    } rule_out_t;

    function automatic deg_sel_t sel_fall(input pt_t x, input pt_t a, input pt_t b);
        deg_sel_t s;
        pt_t      num_w;
        pt_t      den_w;
        num_w  = b - x;
        den_w  = b - a;
        s.num  = num_w[SPAN_BITS-1:0];
        s.den  = den_w[SPAN_BITS-1:0];
        if (x <= a)
        begin
            s.mode = DM_ONE;
        end
        else if (x <= b)
        begin
            s.mode = DM_DIV;
        end
        else
        begin
            s.mode = DM_ZERO;
        end
        return s;
    endfunction

    function automatic deg_sel_t sel_rise(input pt_t x, input pt_t a, input pt_t b);
        deg_sel_t s;
        pt_t      num_w;
        pt_t      den_w;
        num_w  = x - a;
        den_w  = b - a;
        s.num  = num_w[SPAN_BITS-1:0];
        s.den  = den_w[SPAN_BITS-1:0];
        if (x <= a)
        begin
            s.mode = DM_ZERO;
        end
        else if (x <= b)
        begin
            s.mode = DM_DIV;
        end
        else
        begin
            s.mode = DM_ONE;
        end
        return s;
    endfunction

    function automatic deg_sel_t sel_tri(input pt_t x, input pt_t s0, input pt_t p,
                                         input pt_t e);
        deg_sel_t s;
        pt_t      up_num;
        pt_t      up_den;
        pt_t      dn_num;
        pt_t      dn_den;
        up_num = x - s0;
        up_den = p - s0;
        dn_num = e - x;
        dn_den = e - p;
        if (x <= s0)
        begin
            s.mode = DM_ZERO;
            s.num  = up_num[SPAN_BITS-1:0];
            s.den  = up_den[SPAN_BITS-1:0];
        end
        else if (x <= p)
        begin
            s.mode = DM_DIV;
            s.num  = up_num[SPAN_BITS-1:0];
            s.den  = up_den[SPAN_BITS-1:0];
        end
        else if (x <= e)
        begin
            s.mode = DM_DIV;
            s.num  = dn_num[SPAN_BITS-1:0];
            s.den  = dn_den[SPAN_BITS-1:0];
        end
        else
        begin
            s.mode = DM_ZERO;
            s.num  = dn_num[SPAN_BITS-1:0];
            s.den  = dn_den[SPAN_BITS-1:0];
        end
        return s;
    endfunction

    function automatic class_t class_of_rule(input logic [RULE_BITS-1:0] idx);
        class_t c;
        case (idx) inside
            [4'd0:4'd3]: c = CLASS_NORMAL;
            [4'd4:4'd7]: c = CLASS_ALERT;
            4'd8:        c = CLASS_FALL;
            default:     c = CLASS_NORMAL;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/fuzzy_two_sensor_classifier.sv =====
// Two-sensor fuzzy classifier: acceleration and microphone level in, class out.
//
// Input stream s_*: one item per handshake, accel_value and mic_level.
// Output stream m_*: one result item per input item, in order: class_code,
// rule_index and the winning rule strength.
// APB port: eight breakpoint registers at byte address 8*i, read back zero-extended.
//
// An accepted item passes through DEGREE_FRAC_BITS + 6 register stages, the last
// of which drives m_tdata. The dividers take DEGREE_FRAC_BITS + 1 of these
// stages, one quotient bit per stage. Throughput is one item per cycle while
// the receiver does not stall.
//
// Reset empties the pipeline and loads the default breakpoints. When the
// receiver stalls, items hold in place and empty stages behind them still fill;
// s_tready drops only once every stage holds an item.
module fuzzy_two_sensor_classifier
    import fzc_pkg::*;
#(
    parameter int MIC_BITS         = MIC_BITS_DEF,
    parameter int DEGREE_FRAC_BITS = FRAC_BITS_DEF,
    localparam int IN_DATA_BITS    = ((ACC_BITS + MIC_BITS + 7) / 8) * 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // accel_value, mic_level
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // class_code, rule_index, rule_strength
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int F        = DEGREE_FRAC_BITS;
    localparam int ST_DIV   = 2;
    localparam int ST_RULE  = F + 3;
    localparam int N_STAGES = F + 6;

    logic [N_STAGES-1:0]   vld_reg;
    logic [N_STAGES-1:0]   vld_next;
    logic [N_STAGES-1:0]   en;
    acc_cfg_t              acc_cfg;
    logic [3*MIC_BITS-1:0] mic_bps;
    deg_sel_t [2:0]        acc_sel;
    deg_sel_t [2:0]        mic_sel;
    logic [2:0][F:0]       acc_deg;
    logic [2:0][F:0]       mic_deg;
    rule_out_t             result;

    assign pready = 1'b1;

    fzc_regs #(
        .MIC_BITS (MIC_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .acc_cfg (acc_cfg),
        .mic_bps (mic_bps)
    );

    // advance a stage when it is empty or its item moves on
    assign en[N_STAGES-1] = !vld_reg[N_STAGES-1] || m_tready;
    genvar i;
    for (i = 0; i < N_STAGES - 1; i++)
    begin : g_en
        assign en[i] = !vld_reg[i] || en[i+1];
    end

    always_comb
    begin
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int s = 1; s < N_STAGES; s++)
        begin
            vld_next[s] = en[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];

    fzc_fuzz #(
        .MIC_BITS (MIC_BITS)
    ) u_fuzz (
        .clk     (clk),
        .en      (en[1:0]),
        .acc_in  (s_tdata[ACC_BITS-1:0]),
        .mic_in  (s_tdata[ACC_BITS +: MIC_BITS]),
        .acc_cfg (acc_cfg),
        .mic_bps (mic_bps),
        .acc_sel (acc_sel),
        .mic_sel (mic_sel)
    );

    genvar d;
    for (d = 0; d < 3; d++)
    begin : g_div
        fzc_div #(
            .W (ACC_BITS),
            .F (F)
        ) u_acc_div (
            .clk (clk),
            .en  (en[ST_DIV +: F+1]),
            .sel (acc_sel[d]),
            .deg (acc_deg[d])
        );

        fzc_div #(
            .W (MIC_BITS),
            .F (F)
        ) u_mic_div (
            .clk (clk),
            .en  (en[ST_DIV +: F+1]),
            .sel (mic_sel[d]),
            .deg (mic_deg[d])
        );
    end

    fzc_rule #(
        .F (F)
    ) u_rule (
        .clk     (clk),
        .en      (en[ST_RULE +: 3]),
        .acc_deg (acc_deg),
        .mic_deg (mic_deg),
        .result  (result)
    );

    assign m_tvalid = vld_reg[N_STAGES-1];
    assign m_tdata  = {{(OUT_DATA_BITS - CLASS_BITS - RULE_BITS - STRENGTH_BITS){1'b0}},
                       result.strength, result.idx, result.cls};

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> &vld_reg)
        else $error("input blocked while a pipeline stage is empty");

    a_enter_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(vld_reg) == $past($countones(vld_reg))
                 + $past(int'(s_tvalid && s_tready)) - $past(int'(m_tvalid && m_tready)))
        else $error("item lost or duplicated in pipeline");

endmodule

// ===== rtl/fzc_regs.sv =====
module fzc_regs
    import fzc_pkg::*;
#(
    parameter int MIC_BITS = MIC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_BITS-1:0]  paddr,
    input  logic [CFG_DATA_BITS-1:0]  pwdata,
    output logic [CFG_DATA_BITS-1:0]  prdata,
    output acc_cfg_t                  acc_cfg,
    output logic [3*MIC_BITS-1:0]     mic_bps
);

    localparam logic [3*MIC_BITS-1:0] MIC_BPS_RST = {MIC_BITS'(MIC_END_RST),
                                                     MIC_BITS'(MIC_PEAK_RST),
                                                     MIC_BITS'(MIC_START_RST)};

    acc_cfg_t              acc_cfg_reg;
    logic [3*MIC_BITS-1:0] mic_bps_reg;
    cfg_reg_t              reg_sel;
    logic                  wr_en;

    assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_BITS-1:CFG_IDX_LSB]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cfg_reg.low_start  <= ACC_LOW_START_RST;
            acc_cfg_reg.low_end    <= ACC_LOW_END_RST;
            acc_cfg_reg.mid_start  <= ACC_MID_START_RST;
            acc_cfg_reg.mid_peak   <= ACC_MID_PEAK_RST;
            acc_cfg_reg.mid_end    <= ACC_MID_END_RST;
            acc_cfg_reg.high_start <= ACC_HIGH_START_RST;
            acc_cfg_reg.high_end   <= ACC_HIGH_END_RST;
            mic_bps_reg            <= MIC_BPS_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_ACC_LOW_START:  acc_cfg_reg.low_start  <= pwdata[ACC_BITS-1:0];
                REG_ACC_LOW_END:    acc_cfg_reg.low_end    <= pwdata[ACC_BITS-1:0];
                REG_ACC_MID_START:  acc_cfg_reg.mid_start  <= pwdata[ACC_BITS-1:0];
                REG_ACC_MID_PEAK:   acc_cfg_reg.mid_peak   <= pwdata[ACC_BITS-1:0];
                REG_ACC_MID_END:    acc_cfg_reg.mid_end    <= pwdata[ACC_BITS-1:0];
                REG_ACC_HIGH_START: acc_cfg_reg.high_start <= pwdata[ACC_BITS-1:0];
                REG_ACC_HIGH_END:   acc_cfg_reg.high_end   <= pwdata[ACC_BITS-1:0];
                REG_MIC_BPS:        mic_bps_reg            <= pwdata[3*MIC_BITS-1:0];
                default:            mic_bps_reg            <= mic_bps_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ACC_LOW_START:  prdata = CFG_DATA_BITS'(acc_cfg_reg.low_start);
            REG_ACC_LOW_END:    prdata = CFG_DATA_BITS'(acc_cfg_reg.low_end);
            REG_ACC_MID_START:  prdata = CFG_DATA_BITS'(acc_cfg_reg.mid_start);
            REG_ACC_MID_PEAK:   prdata = CFG_DATA_BITS'(acc_cfg_reg.mid_peak);
            REG_ACC_MID_END:    prdata = CFG_DATA_BITS'(acc_cfg_reg.mid_end);
            REG_ACC_HIGH_START: prdata = CFG_DATA_BITS'(acc_cfg_reg.high_start);
            REG_ACC_HIGH_END:   prdata = CFG_DATA_BITS'(acc_cfg_reg.high_end);
            REG_MIC_BPS:        prdata = CFG_DATA_BITS'(mic_bps_reg);
            default:            prdata = '0;
        endcase
    end

    assign acc_cfg = acc_cfg_reg;
    assign mic_bps = mic_bps_reg;

endmodule

// ===== rtl/fzc_fuzz.sv =====
module fzc_fuzz
    import fzc_pkg::*;
#(
    parameter int MIC_BITS = MIC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic [1:0]            en,
    input  logic [ACC_BITS-1:0]   acc_in,
    input  logic [MIC_BITS-1:0]   mic_in,
    input  acc_cfg_t              acc_cfg,
    input  logic [3*MIC_BITS-1:0] mic_bps,
    output deg_sel_t [2:0]        acc_sel,
    output deg_sel_t [2:0]        mic_sel
);

    logic [ACC_BITS-1:0] acc_reg;
    logic [MIC_BITS-1:0] mic_reg;
    deg_sel_t [2:0]      acc_sel_reg;
    deg_sel_t [2:0]      mic_sel_reg;
    deg_sel_t [2:0]      acc_sel_next;
    deg_sel_t [2:0]      mic_sel_next;
    pt_t                 ax;
    pt_t                 mx;
    pt_t                 ms;
    pt_t                 mp;
    pt_t                 me;

    function automatic pt_t acc_pt(input logic [ACC_BITS-1:0] v);
        return $signed({v[ACC_BITS-1], v});
    endfunction

    function automatic pt_t mic_pt(input logic [MIC_BITS-1:0] v);
        return $signed({{(ACC_BITS+1-MIC_BITS){1'b0}}, v});
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            acc_reg <= acc_in;
            mic_reg <= mic_in;
        end
    end

    assign ax = acc_pt(acc_reg);
    assign mx = mic_pt(mic_reg);
    assign ms = mic_pt(mic_bps[0 +: MIC_BITS]);
    assign mp = mic_pt(mic_bps[MIC_BITS +: MIC_BITS]);
    assign me = mic_pt(mic_bps[2*MIC_BITS +: MIC_BITS]);

    always_comb
    begin
        acc_sel_next[0] = sel_fall(ax, acc_pt(acc_cfg.low_start), acc_pt(acc_cfg.low_end));
        acc_sel_next[1] = sel_tri(ax, acc_pt(acc_cfg.mid_start), acc_pt(acc_cfg.mid_peak),
                                  acc_pt(acc_cfg.mid_end));
        acc_sel_next[2] = sel_rise(ax, acc_pt(acc_cfg.high_start), acc_pt(acc_cfg.high_end));
        mic_sel_next[0] = sel_fall(mx, ms, mp);
        mic_sel_next[1] = sel_tri(mx, ms, mp, me);
        mic_sel_next[2] = sel_rise(mx, mp, me);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            acc_sel_reg <= acc_sel_next;
            mic_sel_reg <= mic_sel_next;
        end
    end

    assign acc_sel = acc_sel_reg;
    assign mic_sel = mic_sel_reg;

endmodule

// ===== rtl/fzc_div.sv =====
module fzc_div
    import fzc_pkg::*;
#(
    parameter int W = SPAN_BITS,
    parameter int F = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic [F:0] en,
    input  deg_sel_t sel,
    output logic [F:0] deg
);

    localparam logic [F:0] DEG_ONE = {1'b1, {F{1'b0}}};

    logic [W-1:0] rem_reg  [F];
    logic [W-1:0] den_reg  [F];
    deg_mode_t    mode_reg [F];
    logic [F:0]   q_reg    [F+1];

    genvar j;
    for (j = 0; j <= F; j++)
    begin : g_stage
        logic [W:0]   part;
        logic [W-1:0] den_in;
        logic [F:0]   q_in;
        deg_mode_t    mode_in;
        logic [W:0]   diff;
        logic         ge;
        logic [F:0]   q_shift;
        logic [F:0]   q_next;

        if (j == 0)
        begin : g_first
            assign part    = {1'b0, sel.num[W-1:0]};
            assign den_in  = sel.den[W-1:0];
            assign q_in    = '0;
            assign mode_in = sel.mode;
        end
        else
        begin : g_rest
            assign part    = {rem_reg[j-1], 1'b0};
            assign den_in  = den_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign mode_in = mode_reg[j-1];
        end

        assign diff    = part - {1'b0, den_in};
        assign ge      = !diff[W];
        assign q_shift = {q_in[F-1:0], ge};

        if (j == F)
        begin : g_last
            always_comb
            begin
                case (mode_in)
                    DM_ONE:  q_next = DEG_ONE;
                    DM_DIV:  q_next = q_shift;
                    default: q_next = '0;
                endcase
            end
        end
        else
        begin : g_mid
            logic [W-1:0] rem_next;

            assign q_next   = q_shift;
            assign rem_next = ge ? diff[W-1:0] : part[W-1:0];

            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    rem_reg[j]  <= rem_next;
                    den_reg[j]  <= den_in;
                    mode_reg[j] <= mode_in;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                q_reg[j] <= q_next;
            end
        end
    end

    assign deg = q_reg[F];

endmodule

// ===== rtl/fzc_rule.sv =====
module fzc_rule
    import fzc_pkg::*;
#(
    parameter int F = FRAC_BITS_DEF
)
(
    input  logic            clk,
    input  logic [2:0]      en,
    input  logic [2:0][F:0] acc_deg,
    input  logic [2:0][F:0] mic_deg,
    output rule_out_t       result
);

    localparam int PW = 2 * F + 2;

    logic [PW-1:0]        prod_reg  [9];
    logic [PW-1:0]        best1_reg [3];
    logic [RULE_BITS-1:0] idx1_reg  [3];
    rule_out_t            out_reg;
    logic [1:0]           sel2;
    logic [PW-1:0]        best2;
    logic [RULE_BITS-1:0] idx2;

    // lowest position wins a tie
    function automatic logic [1:0] pick3(input logic [PW-1:0] p0, input logic [PW-1:0] p1,
                                         input logic [PW-1:0] p2);
        logic [1:0] s;
        if (p2 > p0 && p2 > p1)
        begin
            s = 2'd2;
        end
        else if (p1 > p0)
        begin
            s = 2'd1;
        end
        else
        begin
            s = 2'd0;
        end
        return s;
    endfunction

    genvar k;
    for (k = 0; k < 9; k++)
    begin : g_prod
        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                prod_reg[k] <= PW'(acc_deg[k/3]) * PW'(mic_deg[k%3]);
            end
        end
    end

    genvar g;
    for (g = 0; g < 3; g++)
    begin : g_grp
        logic [1:0]    sel1;
        logic [PW-1:0] best1_next;

        assign sel1 = pick3(prod_reg[3*g], prod_reg[3*g+1], prod_reg[3*g+2]);

        always_comb
        begin
            case (sel1)
                2'd1:    best1_next = prod_reg[3*g+1];
                2'd2:    best1_next = prod_reg[3*g+2];
                default: best1_next = prod_reg[3*g];
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (en[1])
            begin
                best1_reg[g] <= best1_next;
                idx1_reg[g]  <= RULE_BITS'(3 * g) + RULE_BITS'(sel1);
            end
        end
    end

    assign sel2 = pick3(best1_reg[0], best1_reg[1], best1_reg[2]);

    always_comb
    begin
        case (sel2)
            2'd1:
            begin
                best2 = best1_reg[1];
                idx2  = idx1_reg[1];
            end
            2'd2:
            begin
                best2 = best1_reg[2];
                idx2  = idx1_reg[2];
            end
            default:
            begin
                best2 = best1_reg[0];
                idx2  = idx1_reg[0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            out_reg.cls      <= class_of_rule(idx2);
            out_reg.idx      <= idx2;
            out_reg.strength <= STRENGTH_BITS'(best2);
        end
    end

    assign result = out_reg;

endmodule
